// ----- design/rgcl_pkg.sv -----
package rgcl_pkg;

  localparam int unsigned CoordW  = 32;
  localparam int unsigned CountW  = 7;
  localparam int unsigned LoadIdxW = 6;
  localparam int unsigned CellW   = 12;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [1:0] KIND_LOAD_X = 2'd0;
  localparam logic [1:0] KIND_LOAD_Y = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_X_COUNT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_Y_COUNT = 2'd1;

  localparam logic [CountW-1:0] COUNT_MIN = 7'd2;

  typedef struct packed {
    logic [1:0]                kind;
    logic [LoadIdxW-1:0]       load_index;
    logic signed [CoordW-1:0]  load_value;
    logic signed [CoordW-1:0]  query_x;
    logic signed [CoordW-1:0]  query_y;
  } rgcl_in_t;

  typedef struct packed {
    logic [CellW-1:0] cell_index;
    logic             outside;
  } rgcl_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FIRST,
    ST_LAST,
    ST_CHECK,
    ST_SCAN,
    ST_DONE
  } rgcl_state_e;

  typedef enum logic [1:0] {
    ADDR_ZERO,
    ADDR_LAST,
    ADDR_NEXT
  } rgcl_addr_sel_e;

  typedef struct packed {
    logic           wr_x;
    logic           wr_y;
    logic           q_load;
    logic           axis_set;
    rgcl_addr_sel_e addr_sel;
    logic           i_clr;
    logic           i_inc;
    logic           ix_save;
    logic           out_set;
    logic           res_load;
  } rgcl_cmd_t;

  typedef struct packed {
    logic lt;
    logic gt;
    logic more;
    logic axis;
    logic outside;
  } rgcl_status_t;

endpackage

// ----- design/rectilinear_grid_cell_lookup.sv -----
// Channel  Signals                                   Dir  Moves
// in       in_valid_i / in_ready_o / in_item_i       in   load x, load y or query item
// out      out_valid_o / out_ready_i / out_item_o    out  cell_index, outside per query
// cfg      cfg_valid_i / cfg_ready_o / cfg_index_i,  in   x_count, y_count writes
//          cfg_data_i
// Load items are taken from idle. A query walks each axis, x then y: it reads the first
// and last entries, checks the bounds, scans the cells, and then posts the result.
// Each coordinate table has a single read port, read one entry a cycle.
// Reset sets both counts to 2; the tables hold nothing until loaded.
// A query waits in its final state while the output register is still full.
module rectilinear_grid_cell_lookup #(
  parameter int unsigned MAX_X_COORDS = 64,
  parameter int unsigned MAX_Y_COORDS = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rgcl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [rgcl_pkg::CountW-1:0]  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  rgcl_pkg::rgcl_in_t           in_item_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rgcl_pkg::rgcl_out_t          out_item_o
);

  rgcl_pkg::rgcl_cmd_t    cmd;
  rgcl_pkg::rgcl_status_t status;

  assign cfg_ready_o = 1'b1;

  rgcl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_kind_i   (in_item_i.kind),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  rgcl_datapath #(
    .MAX_X_COORDS (MAX_X_COORDS),
    .MAX_Y_COORDS (MAX_Y_COORDS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item_o)
  );

endmodule

// ----- design/rgcl_ctrl.sv -----
module rgcl_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_kind_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  rgcl_pkg::rgcl_status_t status_i,
  output rgcl_pkg::rgcl_cmd_t   cmd_o
);

  rgcl_pkg::rgcl_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_fire;
  logic slot_free;

  assign in_ready_o  = (state_q == rgcl_pkg::ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      rgcl_pkg::ST_IDLE: begin
        if (in_fire && in_kind_i == rgcl_pkg::KIND_QUERY) state_d = rgcl_pkg::ST_FIRST;
      end
      rgcl_pkg::ST_FIRST: state_d = rgcl_pkg::ST_LAST;
      rgcl_pkg::ST_LAST:  state_d = rgcl_pkg::ST_CHECK;
      rgcl_pkg::ST_CHECK: begin
        state_d = (status_i.outside || status_i.gt) ? rgcl_pkg::ST_DONE : rgcl_pkg::ST_SCAN;
      end
      rgcl_pkg::ST_SCAN: begin
        if (!(status_i.more && status_i.gt)) begin
          state_d = status_i.axis ? rgcl_pkg::ST_DONE : rgcl_pkg::ST_FIRST;
        end
      end
      rgcl_pkg::ST_DONE: begin
        if (slot_free) state_d = rgcl_pkg::ST_IDLE;
      end
      default: state_d = rgcl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o          = '0;
    cmd_o.addr_sel = rgcl_pkg::ADDR_ZERO;
    case (state_q)
      rgcl_pkg::ST_IDLE: begin
        cmd_o.wr_x   = in_fire && in_kind_i == rgcl_pkg::KIND_LOAD_X;
        cmd_o.wr_y   = in_fire && in_kind_i == rgcl_pkg::KIND_LOAD_Y;
        cmd_o.q_load = in_fire && in_kind_i == rgcl_pkg::KIND_QUERY;
      end
      rgcl_pkg::ST_FIRST: cmd_o.addr_sel = rgcl_pkg::ADDR_ZERO;
      rgcl_pkg::ST_LAST: begin
        cmd_o.addr_sel = rgcl_pkg::ADDR_LAST;
        cmd_o.out_set  = status_i.lt;
      end
      rgcl_pkg::ST_CHECK: begin
        cmd_o.out_set  = status_i.gt;
        cmd_o.i_clr    = 1'b1;
        cmd_o.addr_sel = rgcl_pkg::ADDR_NEXT;
      end
      rgcl_pkg::ST_SCAN: begin
        cmd_o.addr_sel = rgcl_pkg::ADDR_NEXT;
        if (status_i.more && status_i.gt) begin
          cmd_o.i_inc = 1'b1;
        end else if (!status_i.axis) begin
          cmd_o.ix_save  = 1'b1;
          cmd_o.axis_set = 1'b1;
        end
      end
      rgcl_pkg::ST_DONE: cmd_o.res_load = slot_free;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = cmd_o.res_load || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rgcl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ----- design/rgcl_datapath.sv -----
module rgcl_datapath #(
  parameter int unsigned MAX_X_COORDS = 64,
  parameter int unsigned MAX_Y_COORDS = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rgcl_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [rgcl_pkg::CountW-1:0]     cfg_data_i,
  input  rgcl_pkg::rgcl_in_t              in_item_i,
  input  rgcl_pkg::rgcl_cmd_t             cmd_i,
  output rgcl_pkg::rgcl_status_t          status_o,
  output rgcl_pkg::rgcl_out_t             out_item_o
);

  localparam int unsigned XAW = (MAX_X_COORDS > 1) ? $clog2(MAX_X_COORDS) : 1;
  localparam int unsigned YAW = (MAX_Y_COORDS > 1) ? $clog2(MAX_Y_COORDS) : 1;
  localparam int unsigned AW  = (XAW > YAW) ? XAW : YAW;
  localparam int unsigned IW  = (AW > rgcl_pkg::CountW) ? AW : rgcl_pkg::CountW;
  localparam int unsigned CW  = rgcl_pkg::CountW;

  logic [CW-1:0] x_count_q, y_count_q;
  logic [CW-1:0] x_num, y_num, x_last, y_last;
  logic [IW-1:0] last_sel;

  logic [rgcl_pkg::CoordW-1:0] x_mem_q [MAX_X_COORDS];
  logic [rgcl_pkg::CoordW-1:0] y_mem_q [MAX_Y_COORDS];
  logic [rgcl_pkg::CoordW-1:0] x_rd_q, y_rd_q;

  logic signed [rgcl_pkg::CoordW-1:0] qx_q, qy_q, p_sel, d_sel;
  logic          axis_q;
  logic          outside_q;
  logic [IW-1:0] i_q, i_d;
  logic [CW-1:0] ix_q;
  logic [IW-1:0] rd_addr;
  logic          x_idx_ok, y_idx_ok;
  logic [2*CW:0] cell_sum;
  rgcl_pkg::rgcl_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_count_q <= rgcl_pkg::COUNT_MIN;
      y_count_q <= rgcl_pkg::COUNT_MIN;
    end else if (cfg_we_i) begin
      if (cfg_index_i == rgcl_pkg::CFG_X_COUNT) x_count_q <= cfg_data_i;
      if (cfg_index_i == rgcl_pkg::CFG_Y_COUNT) y_count_q <= cfg_data_i;
    end
  end

  always_comb begin
    x_num = (x_count_q < rgcl_pkg::COUNT_MIN) ? rgcl_pkg::COUNT_MIN :
            ((32'(x_count_q) > MAX_X_COORDS) ? CW'(MAX_X_COORDS) : x_count_q);
    y_num = (y_count_q < rgcl_pkg::COUNT_MIN) ? rgcl_pkg::COUNT_MIN :
            ((32'(y_count_q) > MAX_Y_COORDS) ? CW'(MAX_Y_COORDS) : y_count_q);
    x_last   = x_num - 1'b1;
    y_last   = y_num - 1'b1;
    last_sel = axis_q ? IW'(y_last) : IW'(x_last);
  end

  always_comb begin
    i_d = i_q;
    if (cmd_i.i_clr) begin
      i_d = '0;
    end else if (cmd_i.i_inc) begin
      i_d = i_q + 1'b1;
    end
    case (cmd_i.addr_sel)
      rgcl_pkg::ADDR_ZERO: rd_addr = '0;
      rgcl_pkg::ADDR_LAST: rd_addr = last_sel;
      rgcl_pkg::ADDR_NEXT: rd_addr = i_d + 1'b1;
      default:             rd_addr = '0;
    endcase
  end

  assign x_idx_ok = 32'(in_item_i.load_index) < MAX_X_COORDS;
  assign y_idx_ok = 32'(in_item_i.load_index) < MAX_Y_COORDS;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_x && x_idx_ok) begin
      x_mem_q[XAW'(in_item_i.load_index)] <= in_item_i.load_value;
    end
    x_rd_q <= x_mem_q[XAW'(rd_addr)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_y && y_idx_ok) begin
      y_mem_q[YAW'(in_item_i.load_index)] <= in_item_i.load_value;
    end
    y_rd_q <= y_mem_q[YAW'(rd_addr)];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      qx_q <= in_item_i.query_x;
      qy_q <= in_item_i.query_y;
    end
    i_q <= i_d;
    if (cmd_i.ix_save) ix_q <= CW'(i_q);
    if (cmd_i.res_load) begin
      out_q <= outside_q ? rgcl_pkg::rgcl_out_t'{cell_index: '0, outside: 1'b1}
                         : rgcl_pkg::rgcl_out_t'{cell_index: cell_sum[rgcl_pkg::CellW-1:0],
                                                 outside: 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q    <= 1'b0;
      outside_q <= 1'b0;
    end else if (cmd_i.q_load) begin
      axis_q    <= 1'b0;
      outside_q <= 1'b0;
    end else begin
      if (cmd_i.axis_set) axis_q <= 1'b1;
      if (cmd_i.out_set) outside_q <= 1'b1;
    end
  end

  assign p_sel = axis_q ? qy_q : qx_q;
  assign d_sel = axis_q ? $signed(y_rd_q) : $signed(x_rd_q);

  assign cell_sum = (2*CW+1)'(CW'(i_q)) * (2*CW+1)'(x_last) + (2*CW+1)'(ix_q);

  assign status_o.lt      = p_sel < d_sel;
  assign status_o.gt      = p_sel > d_sel;
  assign status_o.more    = i_q < last_sel;
  assign status_o.axis    = axis_q;
  assign status_o.outside = outside_q;
  assign out_item_o       = out_q;

endmodule
